### rtl/rsrq_pkg.sv
// ----------------------------------------------------------------------------
// rsrq_pkg
// Shared command codes and the result record of the ready/starved run queue.
// ----------------------------------------------------------------------------
package rsrq_pkg;

  // Command codes carried in the low bits of the input request
  typedef enum logic [2:0] {
    CMD_ENQ    = 3'd0,
    CMD_DEQ    = 3'd1,
    CMD_RMV    = 3'd2,
    CMD_MOVE   = 3'd3,
    CMD_PUSH   = 3'd4,
    CMD_REFILL = 3'd5
  } cmd_t;

  // One result record, handed from the sequencer to the output register
  typedef struct packed {
    logic [6:0] ready_total;
    logic [6:0] refilled;
    logic       out_valid;
    logic [5:0] out_task;
  } res_t;

  // Widths of the input request bus and the result bus
  localparam int OUT_TDATA_W = 24;
  localparam int IN_TDATA_W  = 16;

endpackage

### rtl/ready_starved_run_queue_top.sv
// ----------------------------------------------------------------------------
// ready_starved_run_queue_top
// Task run queue: doubly linked ready FIFO and singly linked starved stack
// kept as index links in two link memories.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream in_*: one command request per handshake (enqueue, dequeue,
//   remove, move to starved, push starved, refill) with a task slot.
//   Output stream out_*: exactly one result per command, in order.
//   Remove walks the starved stack for the predecessor unless the task heads
//   it; refill moves the starved tasks one at a time; an empty dequeue, an
//   invalid slot for a command that names a task, or an unknown code goes
//   straight to the result.
//   Each step is bound by the single read and write port of the next-link
//   memory; walks read one link at a time.
//   The result lands in an output register once it is formed.
//   One command is in work at a time; the next is taken once the result
//   is in the output register, even if the receiver has not taken it.
//   Reset: a clearing pass writes null into every link, with
//   in_tready low; list heads, the ready count and the outputs clear at once.
//   Receiver stall: the output holds; the block finishes the current command
//   and then waits with in_tready low until the output register drains.
// ----------------------------------------------------------------------------
module ready_starved_run_queue_top #(
  parameter int TASKS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [rsrq_pkg::IN_TDATA_W-1:0]      in_tdata,   // [2:0] command, [8:3] task_id
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [rsrq_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [5:0] out_task, [12:6] refilled,
                                                           // [19:13] ready_total
  output logic [0:0]                           out_tuser   // [0] out_valid
);

  import rsrq_pkg::*;

  localparam int LW = $clog2(TASKS + 1);
  localparam int AW = $clog2(TASKS);

  logic          nx_we, pv_we;
  logic [AW-1:0] nx_waddr, nx_raddr, pv_waddr, pv_raddr;
  logic [LW-1:0] nx_wdata, nx_rdata, pv_wdata, pv_rdata;
  logic          res_valid, res_ready;
  res_t          res;
  cmd_t          in_cmd;

  assign in_cmd = cmd_t'(in_tdata[2:0]);

  // command sequencer
  rsrq_seq #(
    .TASKS(TASKS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_cmd),
    .in_task   (in_tdata[8:3]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .nx_we     (nx_we),
    .nx_waddr  (nx_waddr),
    .nx_wdata  (nx_wdata),
    .nx_raddr  (nx_raddr),
    .nx_rdata  (nx_rdata),
    .pv_we     (pv_we),
    .pv_waddr  (pv_waddr),
    .pv_wdata  (pv_wdata),
    .pv_raddr  (pv_raddr),
    .pv_rdata  (pv_rdata)
  );

  // next-link memory
  rsrq_ram #(
    .WIDTH(LW),
    .DEPTH(TASKS)
  ) u_nx_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (nx_raddr),
    .rdata (nx_rdata)
  );

  // prev-link memory
  rsrq_ram #(
    .WIDTH(LW),
    .DEPTH(TASKS)
  ) u_pv_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .raddr (pv_raddr),
    .rdata (pv_rdata)
  );

  // result register
  rsrq_outreg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### rtl/rsrq_ram.sv
// ----------------------------------------------------------------------------
// rsrq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rsrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/rsrq_seq.sv
// ----------------------------------------------------------------------------
// rsrq_seq
// Command sequencer: list heads, ready count and the read-modify-write steps
// over the next/prev link memories, including the starved-list walks.
// ----------------------------------------------------------------------------
module rsrq_seq #(
  parameter  int TASKS = 64,
  localparam int LW    = $clog2(TASKS + 1),
  localparam int AW    = $clog2(TASKS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // command request
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rsrq_pkg::cmd_t       in_cmd,
  input  logic [5:0]           in_task,
  // result request
  output logic                 res_valid,
  input  logic                 res_ready,
  output rsrq_pkg::res_t       res,
  // next-link memory
  output logic                 nx_we,
  output logic [AW-1:0]        nx_waddr,
  output logic [LW-1:0]        nx_wdata,
  output logic [AW-1:0]        nx_raddr,
  input  logic [LW-1:0]        nx_rdata,
  // prev-link memory
  output logic                 pv_we,
  output logic [AW-1:0]        pv_waddr,
  output logic [LW-1:0]        pv_wdata,
  output logic [AW-1:0]        pv_raddr,
  input  logic [LW-1:0]        pv_rdata
);

  import rsrq_pkg::*;

  localparam logic [LW-1:0] NIL = LW'(TASKS);

  typedef enum logic [19:0] {
    ST_CLEAR  = 20'h00001,
    ST_IDLE   = 20'h00002,
    ST_ENQ_A  = 20'h00004,
    ST_ENQ_B  = 20'h00008,
    ST_DEQ_RD = 20'h00010,
    ST_DEQ_WR = 20'h00020,
    ST_DEQ_PV = 20'h00040,
    ST_UL_RD  = 20'h00080,
    ST_UL_WR  = 20'h00100,
    ST_PUSH   = 20'h00200,
    ST_RM_RD  = 20'h00400,
    ST_RM_NX  = 20'h00800,
    ST_WK_RD  = 20'h01000,
    ST_WK_CHK = 20'h02000,
    ST_RM_FIX = 20'h04000,
    ST_RM_CLR = 20'h08000,
    ST_RF_RD  = 20'h10000,
    ST_RF_WR  = 20'h20000,
    ST_RF_LNK = 20'h40000,
    ST_FIN    = 20'h80000
  } state_t;

  state_t          state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [LW-1:0]   tid_r, tid_nxt;
  logic [LW-1:0]   first_r, first_nxt;
  logic [LW-1:0]   last_r, last_nxt;
  logic [LW-1:0]   sf_r, sf_nxt;
  logic [LW-1:0]   size_r, size_nxt;
  logic [LW-1:0]   cur_r, cur_nxt;
  logic [LW-1:0]   tnx_r, tnx_nxt;
  logic [LW-1:0]   steps_r, steps_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [5:0]      otask_r, otask_nxt;
  logic            ovalid_r, ovalid_nxt;
  logic            in_ok;

  function automatic logic [AW-1:0] adr(input logic [LW-1:0] l);
    return l[AW-1:0];
  endfunction

  function automatic logic [6:0] sat7(input int unsigned v);
    return (v > 32'd127) ? 7'd127 : 7'(v);
  endfunction

  function automatic logic [LW-1:0] inc_sat(input logic [LW-1:0] v);
    return (v < NIL) ? v + LW'(1) : v;
  endfunction

  function automatic logic [LW-1:0] dec_sat(input logic [LW-1:0] v);
    return (v != '0) ? v - LW'(1) : v;
  endfunction

  assign in_ok = (32'(in_task) < TASKS);

  // next-state and memory control
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    tid_nxt    = tid_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    sf_nxt     = sf_r;
    size_nxt   = size_r;
    cur_nxt    = cur_r;
    tnx_nxt    = tnx_r;
    steps_nxt  = steps_r;
    clr_nxt    = clr_r;
    otask_nxt  = otask_r;
    ovalid_nxt = ovalid_r;
    nx_we      = 1'b0;
    nx_waddr   = adr(tid_r);
    nx_wdata   = NIL;
    nx_raddr   = adr(tid_r);
    pv_we      = 1'b0;
    pv_waddr   = adr(tid_r);
    pv_wdata   = NIL;
    pv_raddr   = adr(tid_r);
    in_ready   = (state_r == ST_IDLE);
    res_valid  = (state_r == ST_FIN);

    case (state_r)
      // sweep both link memories to null after reset
      ST_CLEAR: begin
        nx_we    = 1'b1;
        pv_we    = 1'b1;
        nx_waddr = clr_r;
        pv_waddr = clr_r;
        clr_nxt  = clr_r + AW'(1);
        if (clr_r == AW'(TASKS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      // take a request and dispatch
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_cmd;
          tid_nxt    = LW'(in_task);
          otask_nxt  = '0;
          ovalid_nxt = 1'b0;
          steps_nxt  = '0;
          cur_nxt    = sf_r;
          case (in_cmd)
            CMD_ENQ:  state_nxt = in_ok ? ST_ENQ_A : ST_FIN;
            CMD_DEQ:  state_nxt = (first_r != NIL) ? ST_DEQ_RD : ST_FIN;
            CMD_RMV:  state_nxt = in_ok ? ST_UL_RD : ST_FIN;
            CMD_MOVE: state_nxt = in_ok ? ST_UL_RD : ST_FIN;
            CMD_PUSH: state_nxt = in_ok ? ST_PUSH : ST_FIN;
            CMD_REFILL: begin
              sf_nxt    = NIL;
              state_nxt = ST_RF_RD;
            end
            default:  state_nxt = ST_FIN;
          endcase
        end
      end

      // enqueue: own links first, then the old tail
      ST_ENQ_A: begin
        nx_we     = 1'b1;
        pv_we     = 1'b1;
        pv_wdata  = last_r;
        state_nxt = ST_ENQ_B;
      end
      ST_ENQ_B: begin
        if (last_r != NIL) begin
          nx_we    = 1'b1;
          nx_waddr = adr(last_r);
          nx_wdata = tid_r;
        end else begin
          first_nxt = tid_r;
        end
        last_nxt  = tid_r;
        size_nxt  = inc_sat(size_r);
        state_nxt = ST_FIN;
      end

      // dequeue: fetch head successor, detach head
      ST_DEQ_RD: begin
        nx_raddr  = adr(first_r);
        state_nxt = ST_DEQ_WR;
      end
      ST_DEQ_WR: begin
        nx_we      = 1'b1;
        pv_we      = 1'b1;
        nx_waddr   = adr(first_r);
        pv_waddr   = adr(first_r);
        first_nxt  = nx_rdata;
        otask_nxt  = 6'(first_r);
        ovalid_nxt = 1'b1;
        size_nxt   = dec_sat(size_r);
        if (nx_rdata == NIL) begin
          last_nxt  = NIL;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_DEQ_PV;
        end
      end
      ST_DEQ_PV: begin
        pv_we     = 1'b1;
        pv_waddr  = adr(first_r);
        state_nxt = ST_FIN;
      end

      // ready unlink, shared by remove and move
      ST_UL_RD: begin
        state_nxt = ST_UL_WR;
      end
      ST_UL_WR: begin
        if (pv_rdata != NIL) begin
          nx_we    = 1'b1;
          nx_waddr = adr(pv_rdata);
          nx_wdata = nx_rdata;
        end else if (first_r == tid_r) begin
          first_nxt = nx_rdata;
        end
        if (nx_rdata != NIL) begin
          pv_we    = 1'b1;
          pv_waddr = adr(nx_rdata);
          pv_wdata = pv_rdata;
        end else if (last_r == tid_r) begin
          last_nxt = pv_rdata;
        end
        if (cmd_r == CMD_MOVE) begin
          size_nxt  = dec_sat(size_r);
          state_nxt = ST_PUSH;
        end else begin
          state_nxt = ST_RM_RD;
        end
      end

      // push onto the starved stack
      ST_PUSH: begin
        nx_we     = 1'b1;
        pv_we     = 1'b1;
        nx_wdata  = sf_r;
        sf_nxt    = tid_r;
        state_nxt = ST_FIN;
      end

      // remove: re-read own next link after the unlink writes
      ST_RM_RD: begin
        state_nxt = ST_RM_NX;
      end
      ST_RM_NX: begin
        tnx_nxt = nx_rdata;
        if (sf_r == tid_r) begin
          sf_nxt    = nx_rdata;
          state_nxt = ST_RM_CLR;
        end else begin
          cur_nxt   = sf_r;
          steps_nxt = '0;
          state_nxt = ST_WK_RD;
        end
      end

      // starved walk looking for the predecessor, bounded by TASKS steps
      ST_WK_RD: begin
        if (cur_r == NIL) begin
          state_nxt = ST_RM_CLR;
        end else begin
          nx_raddr  = adr(cur_r);
          state_nxt = ST_WK_CHK;
        end
      end
      ST_WK_CHK: begin
        if (nx_rdata == tid_r) begin
          state_nxt = ST_RM_FIX;
        end else if (steps_r == NIL) begin
          state_nxt = ST_RM_CLR;
        end else begin
          cur_nxt   = nx_rdata;
          steps_nxt = steps_r + LW'(1);
          state_nxt = ST_WK_RD;
        end
      end
      ST_RM_FIX: begin
        nx_we     = 1'b1;
        nx_waddr  = adr(cur_r);
        nx_wdata  = tnx_r;
        state_nxt = ST_RM_CLR;
      end
      ST_RM_CLR: begin
        nx_we     = 1'b1;
        pv_we     = 1'b1;
        state_nxt = ST_FIN;
      end

      // refill: pop starved entries head first onto the ready tail
      ST_RF_RD: begin
        if (cur_r == NIL || steps_r == NIL) begin
          state_nxt = ST_FIN;
        end else begin
          nx_raddr  = adr(cur_r);
          state_nxt = ST_RF_WR;
        end
      end
      ST_RF_WR: begin
        tnx_nxt   = nx_rdata;
        nx_we     = 1'b1;
        pv_we     = 1'b1;
        nx_waddr  = adr(cur_r);
        pv_waddr  = adr(cur_r);
        pv_wdata  = last_r;
        state_nxt = ST_RF_LNK;
      end
      ST_RF_LNK: begin
        if (last_r != NIL) begin
          nx_we    = 1'b1;
          nx_waddr = adr(last_r);
          nx_wdata = cur_r;
        end else begin
          first_nxt = cur_r;
        end
        last_nxt  = cur_r;
        size_nxt  = inc_sat(size_r);
        cur_nxt   = tnx_r;
        steps_nxt = steps_r + LW'(1);
        state_nxt = ST_RF_RD;
      end

      // hand the result to the output register
      ST_FIN: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      first_r <= NIL;
      last_r  <= NIL;
      sf_r    <= NIL;
      size_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      sf_r    <= sf_nxt;
      size_r  <= size_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    tid_r    <= tid_nxt;
    cur_r    <= cur_nxt;
    tnx_r    <= tnx_nxt;
    steps_r  <= steps_nxt;
    otask_r  <= otask_nxt;
    ovalid_r <= ovalid_nxt;
  end

  // result record
  always_comb begin
    res.out_task    = otask_r;
    res.out_valid   = ovalid_r;
    res.refilled    = (cmd_r == CMD_REFILL) ? sat7(32'(steps_r)) : 7'd0;
    res.ready_total = sat7(32'(size_r));
  end

endmodule

### rtl/rsrq_outreg.sv
// ----------------------------------------------------------------------------
// rsrq_outreg
// Output register: holds one finished result for the receiver so the
// sequencer can take the next request meanwhile.
// ----------------------------------------------------------------------------
module rsrq_outreg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 res_valid,
  output logic                                 res_ready,
  input  rsrq_pkg::res_t                       res,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [rsrq_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [0:0]                           out_tuser
);

  import rsrq_pkg::*;

  logic valid_r, valid_nxt;
  res_t data_r;

  assign res_ready = !valid_r || out_tready;

  // occupancy
  always_comb begin
    valid_nxt = valid_r;
    if (res_valid && res_ready) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'b0000, data_r.ready_total, data_r.refilled, data_r.out_task};
  assign out_tuser  = data_r.out_valid;

endmodule

### rtl/rsrq_chk.sv
// ----------------------------------------------------------------------------
// rsrq_chk
// Port-level checks of the run queue, bound to the top level.
// ----------------------------------------------------------------------------
module rsrq_chk #(
  parameter int TASKS = 64
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [rsrq_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input logic [0:0]                           out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one command in work at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while a command is in work");

  // a dequeued task never comes with a refill count
  a_deq_no_refill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[12:6] == 7'd0)
    else $error("dequeue result carries a refill count");

  // no task slot without a successful dequeue
  a_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[5:0] == 6'd0)
    else $error("task slot reported without dequeue");

  // ready and refill counts within the slot count
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[19:13]) <= TASKS && 32'(out_tdata[12:6]) <= TASKS)
    else $error("count beyond the number of slots");

endmodule

bind ready_starved_run_queue_top rsrq_chk #(
  .TASKS(TASKS)
) u_rsrq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ready/starved run queue. A scoreboard class
// tracks both linked lists and predicts every result record. Stimulus is a
// short directed list followed by mostly well-formed random requests in
// bursts, with a stalling receiver that once holds off long enough to
// back up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import rsrq_pkg::*;

  localparam int         NSLOT      = 64;
  localparam logic [6:0] NIL        = 7'd64;
  localparam int         RAND_REQS  = 1875;
  localparam int         DRAIN_WAIT = 300;
  localparam int         LIMIT      = 2000000;

  // --------------------------------------------------------------------------
  // Run queue predictor and result scoreboard
  // --------------------------------------------------------------------------
  class run_queue_scoreboard;
    logic [6:0]  nxt [NSLOT];
    logic [6:0]  prv [NSLOT];
    logic [6:0]  rdy_head;
    logic [6:0]  rdy_tail;
    logic [6:0]  stv_head;
    int unsigned rdy_count;
    res_t        expected_q [$];
    int          errors;

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        nxt[i] = NIL;
        prv[i] = NIL;
      end
      rdy_head  = NIL;
      rdy_tail  = NIL;
      stv_head  = NIL;
      rdy_count = 0;
      errors    = 0;
    endfunction

    function logic [6:0] next_of(logic [6:0] n);
      return (n < NSLOT) ? nxt[n[5:0]] : NIL;
    endfunction

    function void set_next(logic [6:0] n, logic [6:0] v);
      if (n < NSLOT) nxt[n[5:0]] = v;
    endfunction

    function void set_prev(logic [6:0] n, logic [6:0] v);
      if (n < NSLOT) prv[n[5:0]] = v;
    endfunction

    function void append_ready(logic [6:0] t);
      nxt[t[5:0]] = NIL;
      prv[t[5:0]] = rdy_tail;
      if (rdy_tail != NIL) set_next(rdy_tail, t);
      else rdy_head = t;
      rdy_tail = t;
      if (rdy_count < NSLOT) rdy_count++;
    endfunction

    function void unlink_ready(logic [6:0] t);
      logic [6:0] p;
      logic [6:0] n;
      p = prv[t[5:0]];
      n = nxt[t[5:0]];
      if (p != NIL) set_next(p, n);
      else if (rdy_head == t) rdy_head = n;
      if (n != NIL) set_prev(n, p);
      else if (rdy_tail == t) rdy_tail = p;
    endfunction

    function void push_starved(logic [6:0] t);
      prv[t[5:0]] = NIL;
      nxt[t[5:0]] = stv_head;
      stv_head = t;
    endfunction

    // Apply one accepted request and queue the result it must produce
    function void note_request(logic [2:0] cmd, logic [5:0] tid);
      res_t       r;
      logic [6:0] t;
      logic [6:0] h;
      logic [6:0] p;
      logic [6:0] s;
      logic [6:0] nx;
      int         steps;
      int         moved;
      r = '0;
      t = {1'b0, tid};
      case (cmd)
        CMD_ENQ: append_ready(t);
        CMD_DEQ: begin
          if (rdy_head < NSLOT) begin
            h = rdy_head;
            rdy_head = nxt[h[5:0]];
            if (rdy_head != NIL) set_prev(rdy_head, NIL);
            else rdy_tail = NIL;
            nxt[h[5:0]] = NIL;
            prv[h[5:0]] = NIL;
            if (rdy_count > 0) rdy_count--;
            r.out_task  = h[5:0];
            r.out_valid = 1'b1;
          end
        end
        CMD_RMV: begin
          unlink_ready(t);
          if (stv_head == t) begin
            stv_head = nxt[t[5:0]];
          end else begin
            // find the starved predecessor; a step bound stops the walk on a cyclic list
            p = stv_head;
            steps = 0;
            while (p != NIL && next_of(p) != t && steps < NSLOT) begin
              p = next_of(p);
              steps++;
            end
            if (p != NIL && next_of(p) == t) set_next(p, nxt[t[5:0]]);
          end
          nxt[t[5:0]] = NIL;
          prv[t[5:0]] = NIL;
        end
        CMD_MOVE: begin
          unlink_ready(t);
          if (rdy_count > 0) rdy_count--;
          push_starved(t);
        end
        CMD_PUSH: push_starved(t);
        CMD_REFILL: begin
          s = stv_head;
          moved = 0;
          stv_head = NIL;
          while (s < NSLOT && moved < NSLOT) begin
            nx = nxt[s[5:0]];
            nxt[s[5:0]] = NIL;
            prv[s[5:0]] = NIL;
            append_ready(s);
            s = nx;
            moved++;
          end
          r.refilled = 7'(moved);
        end
        default: ;
      endcase
      r.ready_total = 7'(rdy_count);
      expected_q.push_back(r);
    endfunction

    // Compare one accepted result against the oldest expectation
    function void check_result(logic [OUT_TDATA_W-1:0] data, logic [0:0] user);
      res_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: tdata=%h tuser=%b", data, user);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (data[5:0] != e.out_task) begin
        $error("out_task expected %0d actual %0d", e.out_task, data[5:0]);
        errors++;
      end
      if (user[0] != e.out_valid) begin
        $error("out_valid expected %0d actual %0d", e.out_valid, user[0]);
        errors++;
      end
      if (data[12:6] != e.refilled) begin
        $error("refilled expected %0d actual %0d", e.refilled, data[12:6]);
        errors++;
      end
      if (data[19:13] != e.ready_total) begin
        $error("ready_total expected %0d actual %0d", e.ready_total, data[19:13]);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;

  run_queue_scoreboard sb = new();
  int burst_left = 0;
  int cycle_count = 0;

  always #6 clk = ~clk;

  ready_starved_run_queue_top #(.TASKS(NSLOT)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request driver: offer one request, hold until taken, then maybe pause
  // --------------------------------------------------------------------------
  task automatic issue(input logic [2:0] cmd, input logic [5:0] tid);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, tid, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(cmd, tid);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(0, 24);
    end
  endtask

  // Random request: mostly consistent with the current lists, some noise.
  // mode 0 fills, mode 1 drains, mode 2 mixes.
  function automatic logic [8:0] pick_request(int mode);
    int         where [NSLOT];
    logic [5:0] free_q [$];
    logic [5:0] rdy_q [$];
    logic [5:0] stv_q [$];
    int         cut [3][5] = '{'{55, 65, 73, 83, 93},
                               '{10, 60, 70, 80, 85},
                               '{25, 50, 65, 80, 90}};
    logic [6:0] p;
    logic [2:0] cmd;
    logic [5:0] tid;
    int         roll;
    for (int i = 0; i < NSLOT; i++) where[i] = 0;
    p = sb.rdy_head;
    for (int k = 0; k < NSLOT && p < NSLOT; k++) begin
      if (where[p[5:0]] == 0) where[p[5:0]] = 1;
      p = sb.nxt[p[5:0]];
    end
    p = sb.stv_head;
    for (int k = 0; k < NSLOT && p < NSLOT; k++) begin
      if (where[p[5:0]] == 0) where[p[5:0]] = 2;
      p = sb.nxt[p[5:0]];
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (where[i] == 0) free_q.push_back(6'(i));
      else if (where[i] == 1) rdy_q.push_back(6'(i));
      else stv_q.push_back(6'(i));
    end

    tid = 6'($urandom_range(0, NSLOT - 1));
    if ($urandom_range(0, 99) < 8) begin
      cmd = 3'($urandom_range(0, 7));
      return {tid, cmd};
    end
    roll = $urandom_range(0, 99);
    if (roll < cut[mode][0]) cmd = CMD_ENQ;
    else if (roll < cut[mode][1]) cmd = CMD_DEQ;
    else if (roll < cut[mode][2]) cmd = CMD_RMV;
    else if (roll < cut[mode][3]) cmd = CMD_MOVE;
    else if (roll < cut[mode][4]) cmd = CMD_PUSH;
    else cmd = CMD_REFILL;

    case (cmd)
      CMD_ENQ, CMD_PUSH: begin
        if (free_q.size() != 0) tid = free_q[$urandom_range(0, free_q.size() - 1)];
        else cmd = CMD_DEQ;
      end
      CMD_MOVE: begin
        if (rdy_q.size() != 0) tid = rdy_q[$urandom_range(0, rdy_q.size() - 1)];
      end
      CMD_RMV: begin
        if (rdy_q.size() != 0 && (stv_q.size() == 0 || $urandom_range(0, 1) == 0))
          tid = rdy_q[$urandom_range(0, rdy_q.size() - 1)];
        else if (stv_q.size() != 0)
          tid = stv_q[$urandom_range(0, stv_q.size() - 1)];
      end
      default: ;
    endcase
    return {tid, cmd};
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int         mode;
    int         mode_left;
    logic [8:0] req;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue corners, unknown codes
    issue(CMD_DEQ, 6'd63);
    issue(CMD_RMV, 6'd5);          // task on no list
    issue(CMD_REFILL, 6'd0);
    issue(3'd6, 6'd0);
    issue(3'd7, 6'd63);
    // basic list traffic
    issue(CMD_ENQ, 6'd0);
    issue(CMD_ENQ, 6'd63);
    issue(CMD_ENQ, 6'd21);
    issue(CMD_MOVE, 6'd63);        // from middle of ready to starved
    issue(CMD_PUSH, 6'd42);
    issue(CMD_PUSH, 6'd7);
    issue(CMD_RMV, 6'd42);         // starved middle
    issue(CMD_RMV, 6'd7);          // starved head
    issue(CMD_REFILL, 6'd0);
    issue(CMD_DEQ, 6'd0);
    issue(CMD_DEQ, 6'd0);
    issue(CMD_DEQ, 6'd0);
    issue(CMD_DEQ, 6'd0);          // empty again
    // double enqueue and a self-looped starved stack
    issue(CMD_ENQ, 6'd33);
    issue(CMD_ENQ, 6'd33);
    issue(CMD_PUSH, 6'd5);
    issue(CMD_PUSH, 6'd5);
    issue(CMD_REFILL, 6'd0);       // walk cut off, count saturates
    issue(CMD_DEQ, 6'd0);
    issue(CMD_RMV, 6'd5);

    mode = 1;
    mode_left = 80;
    repeat (RAND_REQS) begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(60, 150);
      end
      mode_left--;
      req = pick_request(mode);
      issue(req[2:0], req[8:3]);
    end
    in_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result receiver: checks results, stalls on its own pattern, one long hold
  // --------------------------------------------------------------------------
  initial begin : receiver
    int   results;
    int   hold_left;
    int   stall_mode;
    int   mode_left;
    logic take;
    results    = 0;
    hold_left  = 0;
    stall_mode = 0;
    mode_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_result(out_tdata, out_tuser);
        results++;
        if (results == 300) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(16, 128);
        end
        mode_left--;
        case (stall_mode)
          0:       take = 1'b1;
          1:       take = ($urandom_range(0, 3) != 0);
          2:       take = 1'($urandom_range(0, 1));
          default: take = ($urandom_range(0, 4) == 0);
        endcase
        out_tready <= take;
      end
    end
  end

endmodule
